// ----- rtl/sorted_list_engine_defines.svh -----
// Assertion macros for the sorted list engine.
`ifndef SORTED_LIST_ENGINE_DEFINES_SVH
`define SORTED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

`define SLE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted list engine: same-cycle check failed");

`define SLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted list engine: next-cycle check failed");

`else

`define SLE_ASSERT_IMPL(lbl, clk, rst, ante, cons)

`define SLE_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/sle_pkg.sv -----
// Shared types and constants for the sorted list engine.
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VAL_W         = 32;
   localparam int REQ_W         = 2;
   localparam int STATUS_W      = 2;
   localparam int OUT_IDX_W     = 5;

   localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

   typedef struct packed {
      logic                    start;
      logic                    advance;
      logic                    ins;
      logic                    del;
      logic                    descending;
      logic signed [VAL_W-1:0] value;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/sorted_list_engine.sv -----
// Top level of the sorted list engine: request sequencer, count and result register.
//
//   channel   dir   handshake               payload
//   req       in    req_tvalid/req_tready   tdata: value; tuser: req_type
//   rsp       out   rsp_tvalid/rsp_tready   tdata: found, position, status, count_after
//   csr       in    csr_we                  csr_wdata: descending
//
// A request scans, then a delete that hit removes the run of equal entries; in the scan
// a token walks the cell row one cell a cycle to the insertion index.
// Synchronous active-high reset empties the list (valid bits cleared).
// A result waits in the output register; the next request is taken meanwhile and
// only its finish stalls until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_list_engine_defines.svh"

module sorted_list_engine #(
   parameter int DEPTH = sle_pkg::DEPTH_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [sle_pkg::VAL_W-1:0]      req_tdata,   // [31:0] value
   input  wire  [sle_pkg::REQ_W-1:0]      req_tuser,   // [1:0] req_type
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [15:0]                    rsp_tdata,   // [0] found, [5:1] position,
                                                       // [7:6] status, [12:8] count_after
   input  wire                            csr_we,
   input  wire                            csr_wdata    // descending
);
   import sle_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_DEL  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [REQ_W-1:0]        type_ff, type_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic [CW-1:0]           pos_ff, pos_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    found_ff, found_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic                    desc_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [15:0]             rsp_data_ff, rsp_data_in;

   cell_ctl_type            ctl;
   logic                    any_stop;
   logic                    any_eq;
   logic                    full;
   logic                    scan_stop;
   logic                    req_acc;
   logic                    rsp_free;
   logic [CW+4:0]           pos_ext;
   logic [CW+4:0]           cnt_ext;

   sle_array #(.DEPTH(DEPTH)) u_array (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .any_stop (any_stop),
      .any_eq   (any_eq),
      .full     (full)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign scan_stop  = any_stop | (pos_ff == DEPTH_C);
   assign pos_ext    = {5'd0, pos_ff};
   assign cnt_ext    = {5'd0, count_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in       = state_ff;
      type_in        = type_ff;
      value_in       = value_ff;
      pos_in         = pos_ff;
      count_in       = count_ff;
      found_in       = found_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_data_in    = rsp_data_ff;
      ctl.start      = 1'b0;
      ctl.advance    = 1'b0;
      ctl.ins        = 1'b0;
      ctl.del        = 1'b0;
      ctl.descending = desc_ff;
      ctl.value      = value_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               type_in   = req_tuser;
               value_in  = req_tdata;
               pos_in    = '0;
               status_in = STATUS_OK;
               ctl.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!scan_stop) begin
               ctl.advance = 1'b1;
               pos_in      = pos_ff + 1'b1;
            end else begin
               found_in = any_eq;
               state_in = ST_DONE;
               case (type_ff)
                  REQ_INSERT: begin
                     if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ctl.ins  = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  REQ_DELETE: begin
                     if (!any_eq) begin
                        status_in = STATUS_MISS;
                     end else begin
                        state_in = ST_DEL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DEL: begin
            if (any_eq) begin
               ctl.del  = 1'b1;
               count_in = count_ff - 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'd0, cnt_ext[4:0], status_ff, pos_ext[4:0], found_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         desc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            desc_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      value_ff    <= value_in;
      pos_ff      <= pos_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   `SLE_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= DEPTH_C)
   `SLE_ASSERT_IMPL(a_full_matches_count, clock, reset, 1'b1, full == (count_ff == DEPTH_C))
   `SLE_ASSERT_NEXT(a_insert_grows, clock, reset, ctl.ins, count_ff == $past(count_ff) + 1'b1)
   `SLE_ASSERT_NEXT(a_done_loads_rsp, clock, reset, (state_ff == ST_DONE) && rsp_free,
                    rsp_tvalid && (state_ff == ST_IDLE))

endmodule

`default_nettype wire

// ----- rtl/sle_cell.sv -----
// One list cell: entry, valid bit and scan token, shifting with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module sle_cell (
   input  wire                               clock,
   input  wire                               reset,
   input  wire sle_pkg::cell_ctl_type        ctl,
   input  wire                               tok_seed,
   input  wire                               left_tok,
   input  wire signed [sle_pkg::VAL_W-1:0]   left_entry,
   input  wire                               left_valid,
   input  wire signed [sle_pkg::VAL_W-1:0]   right_entry,
   input  wire                               right_valid,
   output logic signed [sle_pkg::VAL_W-1:0]  entry,
   output logic                              valid,
   output logic                              tok,
   output logic                              stop,
   output logic                              eq_hit
);
   import sle_pkg::*;

   logic signed [VAL_W-1:0] entry_ff, entry_in;
   logic                    valid_ff, valid_in;
   logic                    tok_ff, tok_in;
   logic                    passed_ff, passed_in;
   logic                    precedes;
   logic                    eq;

   assign precedes = ctl.descending ? (entry_ff > ctl.value) : (entry_ff < ctl.value);
   assign eq       = (entry_ff == ctl.value);

   assign stop   = tok_ff & (~valid_ff | ~precedes);
   assign eq_hit = tok_ff & valid_ff & eq;
   assign entry  = entry_ff;
   assign valid  = valid_ff;
   assign tok    = tok_ff;

   always_comb begin
      tok_in    = tok_ff;
      passed_in = passed_ff;
      entry_in  = entry_ff;
      valid_in  = valid_ff;
      if (ctl.start) begin
         tok_in    = tok_seed;
         passed_in = 1'b0;
      end else if (ctl.advance) begin
         tok_in    = left_tok;
         passed_in = passed_ff | tok_ff;
      end
      if (ctl.ins) begin
         if (tok_ff) begin
            entry_in = ctl.value;
            valid_in = 1'b1;
         end else if (!passed_ff) begin
            entry_in = left_entry;
            valid_in = left_valid;
         end
      end else if (ctl.del && !passed_ff) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         tok_ff    <= 1'b0;
         passed_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         tok_ff    <= tok_in;
         passed_ff <= passed_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ----- rtl/sle_array.sv -----
// Row of list cells with neighbor links and the scan result reduction.
`timescale 1ns / 1ps
`default_nettype none

module sle_array #(
   parameter int DEPTH = sle_pkg::DEPTH_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire sle_pkg::cell_ctl_type ctl,
   output logic                       any_stop,
   output logic                       any_eq,
   output logic                       full
);
   import sle_pkg::*;

   logic signed [VAL_W-1:0] ent   [DEPTH];
   logic                    vld   [DEPTH];
   logic                    tokv  [DEPTH];
   logic [DEPTH-1:0]        stop_vec;
   logic [DEPTH-1:0]        eq_vec;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic                    l_tok;
         logic signed [VAL_W-1:0] l_entry;
         logic                    l_valid;
         logic signed [VAL_W-1:0] r_entry;
         logic                    r_valid;

         if (i == 0) begin : g_left_edge
            assign l_tok   = 1'b0;
            assign l_entry = '0;
            assign l_valid = 1'b0;
         end else begin : g_left
            assign l_tok   = tokv[i-1];
            assign l_entry = ent[i-1];
            assign l_valid = vld[i-1];
         end

         if (i == DEPTH - 1) begin : g_right_edge
            assign r_entry = '0;
            assign r_valid = 1'b0;
         end else begin : g_right
            assign r_entry = ent[i+1];
            assign r_valid = vld[i+1];
         end

         sle_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .tok_seed    (i == 0),
            .left_tok    (l_tok),
            .left_entry  (l_entry),
            .left_valid  (l_valid),
            .right_entry (r_entry),
            .right_valid (r_valid),
            .entry       (ent[i]),
            .valid       (vld[i]),
            .tok         (tokv[i]),
            .stop        (stop_vec[i]),
            .eq_hit      (eq_vec[i])
         );
      end
   endgenerate

   assign any_stop = |stop_vec;
   assign any_eq   = |eq_vec;
   assign full     = vld[DEPTH-1];

endmodule

`default_nettype wire

// ----- dv/sorted_list_checker.sv -----
// Scoreboard for the sorted list engine: mirrors the list, predicts each response beat, compares.
`timescale 1ns / 1ps

module sorted_list_checker #(
   parameter int DEPTH = sle_pkg::DEPTH_DEFAULT
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   input  wire                       req_tready,
   input  wire  [sle_pkg::VAL_W-1:0] req_tdata,
   input  wire  [sle_pkg::REQ_W-1:0] req_tuser,
   input  wire                       rsp_tvalid,
   input  wire                       rsp_tready,
   input  wire  [15:0]               rsp_tdata,
   input  wire                       csr_we,
   input  wire                       csr_wdata,
   output logic [31:0]               fail_count,
   output logic [31:0]               pending,
   output logic [31:0]               full_rejects,
   output logic [31:0]               delete_misses
);
   import sle_pkg::*;

   typedef struct packed {
      logic [2:0]          pad;
      logic [4:0]          count_after;
      logic [STATUS_W-1:0] status;
      logic [4:0]          position;
      logic                found;
   } lookup_result_type;

   logic signed [VAL_W-1:0] list_q [DEPTH];
   int unsigned             held = 0;
   bit                      desc_mode = 1'b0;
   lookup_result_type       result_q [$];
   int unsigned             n_fail = 0;
   int unsigned             n_full = 0;
   int unsigned             n_miss = 0;
   int unsigned             beat_no = 0;

   initial begin
      for (int i = 0; i < DEPTH; i++) list_q[i] = '0;
      fail_count    = '0;
      pending       = '0;
      full_rejects  = '0;
      delete_misses = '0;
   end

   function automatic bit ahead_of(input logic signed [VAL_W-1:0] a,
                                   input logic signed [VAL_W-1:0] b);
      return desc_mode ? (a > b) : (a < b);
   endfunction

   // Lookup at the first entry not ahead of v, then apply the request to the mirror.
   function automatic lookup_result_type apply_request(input logic [REQ_W-1:0] kind,
                                                       input logic signed [VAL_W-1:0] v);
      lookup_result_type r;
      int unsigned       idx;
      int unsigned       stop;
      int unsigned       run;
      int unsigned       i;
      r   = '0;
      idx = held;
      for (i = 0; i < held; i++)
         if (idx == held && !ahead_of(list_q[i], v)) idx = i;
      r.found    = (idx < held) && (list_q[idx] == v);
      r.position = 5'(idx);
      r.status   = STATUS_OK;
      if (kind == REQ_INSERT) begin
         if (held >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            for (i = held; i > idx; i--) list_q[i] = list_q[i-1];
            list_q[idx] = v;
            held++;
         end
      end else if (kind == REQ_DELETE) begin
         if (!r.found) begin
            r.status = STATUS_MISS;
         end else begin
            stop = idx;
            while (stop < held && list_q[stop] == v) stop++;
            run = stop - idx;
            for (i = stop; i < held; i++) list_q[i-run] = list_q[i];
            held -= run;
         end
      end
      r.count_after = 5'(held);
      return r;
   endfunction

   always @(posedge clock) begin : score
      lookup_result_type got;
      lookup_result_type want;
      if (reset) begin
         held      = 0;
         desc_mode = 1'b0;
         result_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = lookup_result_type'(rsp_tdata);
            beat_no++;
            if (result_q.size() == 0) begin
               n_fail++;
               if (n_fail <= 10)
                  $display("rsp beat %0d: no response expected, got %h", beat_no, rsp_tdata);
            end else begin
               want = result_q.pop_front();
               if (got.found !== want.found || got.position !== want.position ||
                   got.status !== want.status || got.count_after !== want.count_after ||
                   got.pad !== want.pad) begin
                  n_fail++;
                  if (n_fail <= 10) begin
                     $display("rsp beat %0d: exp found=%0d pos=%0d status=%0d count=%0d pad=%0d",
                              beat_no, want.found, want.position, want.status,
                              want.count_after, want.pad);
                     $display("rsp beat %0d: got found=%0d pos=%0d status=%0d count=%0d pad=%0d",
                              beat_no, got.found, got.position, got.status,
                              got.count_after, got.pad);
                  end
               end
            end
         end
         if (csr_we) desc_mode = csr_wdata;
         if (req_tvalid && req_tready) begin
            want = apply_request(req_tuser, req_tdata);
            if (want.status == STATUS_FULL) n_full++;
            if (want.status == STATUS_MISS) n_miss++;
            result_q.push_back(want);
         end
      end
      fail_count    <= n_fail;
      pending       <= result_q.size();
      full_rejects  <= n_full;
      delete_misses <= n_miss;
   end

endmodule

// ----- dv/sorted_list_engine_tb.sv -----
// Testbench top for the sorted list engine: clock, reset, request and mode stimulus, verdict.
`timescale 1ns / 1ps

module sorted_list_engine_tb;
   import sle_pkg::*;

   localparam int               DEPTH         = DEPTH_DEFAULT;
   localparam logic [REQ_W-1:0] REQ_SPARE     = 2'd3;
   localparam int               PHASES        = 12;
   localparam int               PHASE_ITEMS   = 48;
   localparam int               POOL          = 8;
   localparam int               HOLD_CYCLES   = 400;
   localparam int               STALL_LIMIT   = 3000;
   localparam int               SETTLE_CYCLES = 60;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [VAL_W-1:0]  req_tdata;
   logic [REQ_W-1:0]  req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [15:0]       rsp_tdata;
   logic              csr_we;
   logic              csr_wdata;
   logic [31:0]       fail_count;
   logic [31:0]       pending;
   logic [31:0]       full_rejects;
   logic [31:0]       delete_misses;

   bit                no_idle = 1'b0;
   bit                hold_rsp = 1'b0;
   int unsigned       sent = 0;
   int unsigned       mode_writes = 0;
   int unsigned       quiet_cycles = 0;
   logic [VAL_W-1:0]  pool [POOL];
   int                ins_pct;
   int                del_pct;

   sorted_list_engine #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   sorted_list_checker #(.DEPTH(DEPTH)) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .full_rejects  (full_rejects),
      .delete_misses (delete_misses)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Response side: random backpressure, one long hold on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_tready <= no_idle || ($urandom_range(99) >= 12);
      end
   end

   task automatic send_req(input logic [REQ_W-1:0] kind, input logic [VAL_W-1:0] v);
      if (!no_idle && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input bit desc);
      csr_we    <= 1'b1;
      csr_wdata <= desc;
      @(posedge clock);
      csr_we    <= 1'b0;
      mode_writes++;
   endtask

   // Mostly pool values so finds and deletes hit and duplicates pile up.
   function automatic logic [VAL_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) return pool[$urandom_range(POOL-1)];
      if (r < 80) begin
         case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            default: return '1;
         endcase
      end
      return $urandom();
   endfunction

   function automatic logic [REQ_W-1:0] pick_kind();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 3) return REQ_SPARE;
      if (r < 3 + ins_pct) return REQ_INSERT;
      if (r < 3 + ins_pct + del_pct) return REQ_DELETE;
      return REQ_FIND;
   endfunction

   initial begin
      int unsigned directed_count;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_FIND;
      csr_we     = 1'b0;
      csr_wdata  = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, extremes, duplicates, full list, spare code, run delete
      send_req(REQ_FIND, '0);
      send_req(REQ_DELETE, 32'd5);
      send_req(REQ_INSERT, 32'h8000_0000);
      send_req(REQ_INSERT, 32'h7fff_ffff);
      send_req(REQ_INSERT, '0);
      send_req(REQ_INSERT, '1);
      send_req(REQ_INSERT, '0);
      send_req(REQ_INSERT, '0);
      for (int i = 0; i < 10; i++)
         send_req(REQ_INSERT, (i % 2) ? -(i * 1000 + 7) : (i * 1000 + 7));
      send_req(REQ_INSERT, 32'd5);
      send_req(REQ_FIND, '0);
      send_req(REQ_SPARE, 32'h7fff_ffff);
      send_req(REQ_DELETE, '0);
      send_req(REQ_DELETE, '0);
      send_req(REQ_DELETE, 32'h7fff_ffff);
      directed_count = sent;

      for (int p = 0; p < PHASES; p++) begin
         drain();
         // order flips while entries are held
         write_mode((p % 4 == 1) || (p % 4 == 2));
         for (int k = 0; k < POOL; k++)
            pool[k] = (k < POOL / 2) ? 32'($urandom_range(40)) - 32'd20 : $urandom();
         case (p % 3)
            0: begin
               ins_pct = 70;
               del_pct = 10;
            end
            1: begin
               ins_pct = 20;
               del_pct = 55;
            end
            default: begin
               ins_pct = 40;
               del_pct = 30;
            end
         endcase
         no_idle = (p == 6);
         if (p == 3) hold_rsp = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) send_req(pick_kind(), pick_value());
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d requests (%0d directed) over %0d mode writes in both orders;",
               sent, directed_count, mode_writes);
      $display("  %0d inserts hit a full list, %0d deletes found nothing, %0d mismatches.",
               full_rejects, delete_misses, fail_count);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
